// ----- hw/rtl/pca_pkg.sv -----
// package for the pwm channel and timer allocator
// request and response types, status and action codes, sequencer states
// no dependencies
package pca_pkg;

  // field widths fixed by the request and response formats
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned PIN_W  = 6;
  localparam int unsigned FREQ_W = 26;
  localparam int unsigned RES_W  = 5;
  localparam int unsigned DUTY_W = 16;
  localparam int unsigned FADE_W = 16;
  localparam int unsigned RC_W   = 5;
  localparam int unsigned STS_W  = 3;
  localparam int unsigned CH_W   = 4;
  localparam int unsigned TMR_W  = 3;

  // timer memory word: frequency, resolution, reference count
  localparam int unsigned TMEM_W = FREQ_W + RES_W + RC_W;

  // action codes
  localparam logic [ACT_W-1:0] ACT_OPEN  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DUTY  = 2'd2;

  // status codes
  localparam logic [STS_W-1:0] STS_OK          = 3'd0;
  localparam logic [STS_W-1:0] STS_PIN_OPEN    = 3'd1;
  localparam logic [STS_W-1:0] STS_NO_RESOURCE = 3'd2;
  localparam logic [STS_W-1:0] STS_BAD_RES     = 3'd3;
  localparam logic [STS_W-1:0] STS_NOT_FOUND   = 3'd4;

  // accepted resolution range and count limit
  localparam logic [RES_W-1:0] RES_MIN = 5'd10;
  localparam logic [RES_W-1:0] RES_MAX = 5'd15;
  localparam logic [RC_W-1:0]  REF_MAX = 5'd31;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [PIN_W-1:0]  pin;
    logic [FREQ_W-1:0] frequency;
    logic [RES_W-1:0]  resolution;
    logic [DUTY_W-1:0] duty_value;
    logic [FADE_W-1:0] fade_time;
  } pca_req_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [CH_W-1:0]   channel_index;
    logic [TMR_W-1:0]  timer_id;
    logic              configure_timer;
    logic              release_timer;
    logic [DUTY_W-1:0] duty_out;
    logic [FADE_W-1:0] fade_out;
    logic              fading;
  } pca_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT,
    S_TIMER,
    S_CLOSE,
    S_DONE
  } pca_state_e;

endpackage

// ----- hw/rtl/pca_ram.sv -----
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module pca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pca_ctrl.sv -----
// sequencer of the allocator: slot scan, timer scan, read-modify-write of both memories
// depends on pca_pkg; drives the ports of the slot and timer memories
module pca_ctrl #(
  parameter int unsigned GROUPS             = 2,
  parameter int unsigned CHANNELS_PER_GROUP = 8,
  parameter int unsigned TIMERS_PER_GROUP   = 4,
  parameter int unsigned SLOTS              = GROUPS * CHANNELS_PER_GROUP,
  parameter int unsigned TIMERS             = GROUPS * TIMERS_PER_GROUP,
  parameter int unsigned SW                 = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int unsigned TW                 = (TIMERS > 1) ? $clog2(TIMERS) : 1,
  parameter int unsigned SMW                = pca_pkg::PIN_W + TW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pca_pkg::pca_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pca_pkg::pca_rsp_t out_rsp_o,
  output logic              smem_we_o,
  output logic [SW-1:0]     smem_waddr_o,
  output logic [SMW-1:0]    smem_wdata_o,
  output logic [SW-1:0]     smem_raddr_o,
  input  logic [SMW-1:0]    smem_rdata_i,
  output logic              tmem_we_o,
  output logic [TW-1:0]     tmem_waddr_o,
  output logic [pca_pkg::TMEM_W-1:0] tmem_wdata_o,
  output logic [TW-1:0]     tmem_raddr_o,
  input  logic [pca_pkg::TMEM_W-1:0] tmem_rdata_i
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned PW = (CHANNELS_PER_GROUP > 1) ? $clog2(CHANNELS_PER_GROUP) : 1;
  localparam int unsigned KW = $clog2(TIMERS_PER_GROUP + 1);
  localparam int unsigned RC_LO  = 0;
  localparam int unsigned RES_LO = pca_pkg::RC_W;
  localparam int unsigned FRQ_LO = pca_pkg::RC_W + pca_pkg::RES_W;

  pca_pkg::pca_state_e state_q, state_d;
  pca_pkg::pca_req_t   req_q, req_d;
  pca_pkg::pca_rsp_t   res_q, res_d;
  pca_pkg::pca_rsp_t   out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [SLOTS-1:0]  slot_in_use_q, slot_in_use_d;
  logic [TIMERS-1:0] timer_valid_q, timer_valid_d;

  // slot scan pointers
  logic [CW-1:0] iss_cnt_q, iss_cnt_d;
  logic [PW-1:0] iss_pos_q, iss_pos_d;
  logic [TW-1:0] iss_tb_q, iss_tb_d;
  logic          rd_vld_q, rd_vld_d;
  logic [SW-1:0] rd_idx_q, rd_idx_d;
  logic [TW-1:0] rd_tb_q, rd_tb_d;

  // slot scan findings
  logic [SW-1:0] hit_slot_q, hit_slot_d;
  logic [TW-1:0] hit_tmr_q, hit_tmr_d;
  logic          free_q, free_d;
  logic [SW-1:0] free_slot_q, free_slot_d;
  logic [TW-1:0] free_tb_q, free_tb_d;

  // timer scan pointers and findings
  logic [KW-1:0] t_iss_q, t_iss_d;
  logic          t_rd_vld_q, t_rd_vld_d;
  logic [TW-1:0] t_rd_idx_q, t_rd_idx_d;
  logic          t_rd_last_q, t_rd_last_d;
  logic          zero_q, zero_d;
  logic [TW-1:0] zero_tmr_q, zero_tmr_d;

  // slot memory read decode
  logic [pca_pkg::PIN_W-1:0] s_pin;
  logic [TW-1:0]             s_tmr;
  logic                      s_used, s_hit, s_last, s_end, s_free_now;

  assign s_pin      = smem_rdata_i[SMW-1:TW];
  assign s_tmr      = smem_rdata_i[TW-1:0];
  assign s_used     = slot_in_use_q[rd_idx_q];
  assign s_hit      = rd_vld_q && s_used && (s_pin == req_q.pin);
  assign s_last     = rd_vld_q && (rd_idx_q == SW'(SLOTS - 1));
  assign s_end      = s_hit || s_last;
  assign s_free_now = free_q || (rd_vld_q && !s_used);

  // timer memory read decode, entries never written read as zero
  logic                       t_v;
  logic [pca_pkg::FREQ_W-1:0] t_freq;
  logic [pca_pkg::RES_W-1:0]  t_res;
  logic [pca_pkg::RC_W-1:0]   t_rc;
  logic                       t_match, t_zero, t_end, zero_now;
  logic [TW-1:0]              zero_idx;
  logic                       res_ok;

  assign t_v    = timer_valid_q[(state_q == pca_pkg::S_CLOSE) ? hit_tmr_q : t_rd_idx_q];
  assign t_freq = t_v ? tmem_rdata_i[pca_pkg::TMEM_W-1:FRQ_LO] : '0;
  assign t_res  = t_v ? tmem_rdata_i[FRQ_LO-1:RES_LO] : '0;
  assign t_rc   = t_v ? tmem_rdata_i[RES_LO-1:RC_LO] : '0;

  assign t_match  = t_rd_vld_q && (t_freq == req_q.frequency) && (t_res == req_q.resolution);
  assign t_zero   = t_rd_vld_q && (t_rc == '0);
  assign t_end    = t_match || (t_rd_vld_q && t_rd_last_q);
  assign zero_now = zero_q || t_zero;
  assign zero_idx = zero_q ? zero_tmr_q : t_rd_idx_q;
  assign res_ok   = (req_q.resolution inside {[pca_pkg::RES_MIN:pca_pkg::RES_MAX]});

  logic out_go;
  assign out_go = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pca_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.action inside {pca_pkg::ACT_OPEN, pca_pkg::ACT_CLOSE,
                                      pca_pkg::ACT_DUTY}) begin
            state_d = pca_pkg::S_SLOT;
          end else begin
            state_d = pca_pkg::S_DONE;
          end
        end
      end
      pca_pkg::S_SLOT: begin
        if (s_end) begin
          if (req_q.action == pca_pkg::ACT_CLOSE && s_hit) begin
            state_d = pca_pkg::S_CLOSE;
          end else if (req_q.action == pca_pkg::ACT_OPEN && !s_hit && s_free_now) begin
            state_d = pca_pkg::S_TIMER;
          end else begin
            state_d = pca_pkg::S_DONE;
          end
        end
      end
      pca_pkg::S_TIMER: begin
        if (t_end) begin
          state_d = pca_pkg::S_DONE;
        end
      end
      pca_pkg::S_CLOSE: begin
        state_d = pca_pkg::S_DONE;
      end
      pca_pkg::S_DONE: begin
        if (out_go) begin
          state_d = pca_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pca_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and memory ports
  always_comb begin
    logic                     commit;
    logic [TW-1:0]            c_tmr;
    logic [pca_pkg::RC_W-1:0] c_rc;
    logic                     c_claim;
    logic [pca_pkg::RC_W-1:0] rc_dec;

    commit  = 1'b0;
    c_tmr   = t_rd_idx_q;
    c_rc    = t_rc;
    c_claim = 1'b0;
    rc_dec  = t_rc - pca_pkg::RC_W'(1);

    req_d         = req_q;
    res_d         = res_q;
    slot_in_use_d = slot_in_use_q;
    timer_valid_d = timer_valid_q;
    iss_cnt_d     = iss_cnt_q;
    iss_pos_d     = iss_pos_q;
    iss_tb_d      = iss_tb_q;
    rd_vld_d      = 1'b0;
    rd_idx_d      = rd_idx_q;
    rd_tb_d       = rd_tb_q;
    hit_slot_d    = hit_slot_q;
    hit_tmr_d     = hit_tmr_q;
    free_d        = free_q;
    free_slot_d   = free_slot_q;
    free_tb_d     = free_tb_q;
    t_iss_d       = t_iss_q;
    t_rd_vld_d    = 1'b0;
    t_rd_idx_d    = t_rd_idx_q;
    t_rd_last_d   = t_rd_last_q;
    zero_d        = zero_q;
    zero_tmr_d    = zero_tmr_q;

    smem_we_o    = 1'b0;
    smem_waddr_o = free_slot_q;
    smem_wdata_o = {req_q.pin, c_tmr};
    smem_raddr_o = iss_cnt_q[SW-1:0];
    tmem_we_o    = 1'b0;
    tmem_waddr_o = c_tmr;
    tmem_wdata_o = '0;
    tmem_raddr_o = TW'(free_tb_q + TW'(t_iss_q));

    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      // take a request and clear the scan state
      pca_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d     = in_req_i;
          res_d     = '0;
          iss_cnt_d = '0;
          iss_pos_d = '0;
          iss_tb_d  = '0;
          free_d    = 1'b0;
          zero_d    = 1'b0;
          t_iss_d   = '0;
        end
      end

      // walk the slot memory, one read issued per cycle
      pca_pkg::S_SLOT: begin
        if (iss_cnt_q < CW'(SLOTS)) begin
          rd_vld_d  = 1'b1;
          rd_idx_d  = iss_cnt_q[SW-1:0];
          rd_tb_d   = iss_tb_q;
          iss_cnt_d = iss_cnt_q + CW'(1);
          if (iss_pos_q == PW'(CHANNELS_PER_GROUP - 1)) begin
            iss_pos_d = '0;
            iss_tb_d  = TW'(iss_tb_q + TW'(TIMERS_PER_GROUP));
          end else begin
            iss_pos_d = iss_pos_q + PW'(1);
          end
        end
        if (rd_vld_q && !s_used && !free_q) begin
          free_d      = 1'b1;
          free_slot_d = rd_idx_q;
          free_tb_d   = rd_tb_q;
        end
        if (s_hit) begin
          hit_slot_d = rd_idx_q;
          hit_tmr_d  = s_tmr;
        end
        if (s_end) begin
          case (req_q.action)
            pca_pkg::ACT_OPEN: begin
              if (s_hit) begin
                res_d.status = pca_pkg::STS_PIN_OPEN;
              end else if (!s_free_now) begin
                res_d.status = pca_pkg::STS_NO_RESOURCE;
              end
            end
            pca_pkg::ACT_CLOSE: begin
              if (s_hit) begin
                tmem_raddr_o = s_tmr;
              end else begin
                res_d.status = pca_pkg::STS_NOT_FOUND;
              end
            end
            pca_pkg::ACT_DUTY: begin
              if (s_hit) begin
                res_d.status        = pca_pkg::STS_OK;
                res_d.channel_index = pca_pkg::CH_W'(rd_idx_q);
                res_d.timer_id      = pca_pkg::TMR_W'(s_tmr);
                res_d.duty_out      = req_q.duty_value;
                res_d.fade_out      = req_q.fade_time;
                res_d.fading        = (req_q.fade_time != '0);
              end else begin
                res_d.status = pca_pkg::STS_NOT_FOUND;
              end
            end
            default: begin
              res_d = '0;
            end
          endcase
        end
      end

      // walk the timers of the free slot's group
      pca_pkg::S_TIMER: begin
        if (t_iss_q < KW'(TIMERS_PER_GROUP)) begin
          t_rd_vld_d  = 1'b1;
          t_rd_idx_d  = TW'(free_tb_q + TW'(t_iss_q));
          t_rd_last_d = (t_iss_q == KW'(TIMERS_PER_GROUP - 1));
          t_iss_d     = t_iss_q + KW'(1);
        end
        if (t_zero && !zero_q) begin
          zero_d     = 1'b1;
          zero_tmr_d = t_rd_idx_q;
        end
        if (t_end) begin
          if (t_match) begin
            commit = 1'b1;
          end else if (!zero_now) begin
            res_d.status = pca_pkg::STS_NO_RESOURCE;
          end else if (!res_ok) begin
            res_d.status = pca_pkg::STS_BAD_RES;
          end else begin
            commit  = 1'b1;
            c_tmr   = zero_idx;
            c_rc    = '0;
            c_claim = 1'b1;
          end
        end
        // bind the slot and bump the timer count
        if (commit) begin
          tmem_we_o    = 1'b1;
          tmem_waddr_o = c_tmr;
          tmem_wdata_o = {req_q.frequency, req_q.resolution,
                          (c_rc < pca_pkg::REF_MAX) ? c_rc + pca_pkg::RC_W'(1) : c_rc};
          timer_valid_d[c_tmr] = 1'b1;
          smem_we_o    = 1'b1;
          smem_waddr_o = free_slot_q;
          smem_wdata_o = {req_q.pin, c_tmr};
          slot_in_use_d[free_slot_q] = 1'b1;
          res_d.status          = pca_pkg::STS_OK;
          res_d.channel_index   = pca_pkg::CH_W'(free_slot_q);
          res_d.timer_id        = pca_pkg::TMR_W'(c_tmr);
          res_d.configure_timer = c_claim;
        end
      end

      // drop the timer count and free the slot
      pca_pkg::S_CLOSE: begin
        if (t_rc != '0) begin
          tmem_we_o    = 1'b1;
          tmem_waddr_o = hit_tmr_q;
          tmem_wdata_o = {t_freq, t_res, rc_dec};
        end
        slot_in_use_d[hit_slot_q] = 1'b0;
        res_d.status        = pca_pkg::STS_OK;
        res_d.channel_index = pca_pkg::CH_W'(hit_slot_q);
        res_d.timer_id      = pca_pkg::TMR_W'(hit_tmr_q);
        res_d.release_timer = (t_rc != '0) && (rc_dec == '0);
      end

      // hand the response to the output register
      pca_pkg::S_DONE: begin
        if (out_go) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end

      default: begin
        res_d = res_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pca_pkg::S_IDLE;
      out_valid_q   <= 1'b0;
      slot_in_use_q <= '0;
      timer_valid_q <= '0;
      rd_vld_q      <= 1'b0;
      t_rd_vld_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      slot_in_use_q <= slot_in_use_d;
      timer_valid_q <= timer_valid_d;
      rd_vld_q      <= rd_vld_d;
      t_rd_vld_q    <= t_rd_vld_d;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    res_q       <= res_d;
    out_q       <= out_d;
    iss_cnt_q   <= iss_cnt_d;
    iss_pos_q   <= iss_pos_d;
    iss_tb_q    <= iss_tb_d;
    rd_idx_q    <= rd_idx_d;
    rd_tb_q     <= rd_tb_d;
    hit_slot_q  <= hit_slot_d;
    hit_tmr_q   <= hit_tmr_d;
    free_q      <= free_d;
    free_slot_q <= free_slot_d;
    free_tb_q   <= free_tb_d;
    t_iss_q     <= t_iss_d;
    t_rd_idx_q  <= t_rd_idx_d;
    t_rd_last_q <= t_rd_last_d;
    zero_q      <= zero_d;
    zero_tmr_q  <= zero_tmr_d;
  end

  assign in_stall_o  = (state_q != pca_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ----- hw/rtl/pwm_channel_timer_allocator.sv -----
// top level of the pwm channel and timer allocator
// depends on pca_pkg, pca_ram (slot and timer memories) and pca_ctrl
//
//   channel  dir  handshake             payload
//   in       in   in_valid_i/in_stall_o   in_req_i  (pca_req_t)
//   out      out  out_valid_o/out_stall_i out_rsp_o (pca_rsp_t)
//
// close and set duty stop the slot scan at the pin's slot; an unknown action skips
// the scans; the slot memory read port walks one slot per cycle
// reset clears the slot in-use bits and the timer valid bits at once, no sweep
// one request is in work at a time; in_stall_o is high from acceptance until
// the response has moved into the output register, which out_stall_i holds;
// the next request is taken in the cycle after that move
module pwm_channel_timer_allocator #(
  parameter int unsigned GROUPS             = 2,
  parameter int unsigned CHANNELS_PER_GROUP = 8,
  parameter int unsigned TIMERS_PER_GROUP   = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pca_pkg::pca_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pca_pkg::pca_rsp_t out_rsp_o
);

  localparam int unsigned SLOTS  = GROUPS * CHANNELS_PER_GROUP;
  localparam int unsigned TIMERS = GROUPS * TIMERS_PER_GROUP;
  localparam int unsigned SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TW     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int unsigned SMW    = pca_pkg::PIN_W + TW;

  logic                       smem_we;
  logic [SW-1:0]              smem_waddr, smem_raddr;
  logic [SMW-1:0]             smem_wdata, smem_rdata;
  logic                       tmem_we;
  logic [TW-1:0]              tmem_waddr, tmem_raddr;
  logic [pca_pkg::TMEM_W-1:0] tmem_wdata, tmem_rdata;

  // slot memory: pin and bound timer of each channel slot
  pca_ram #(
    .WIDTH (SMW),
    .DEPTH (SLOTS)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (smem_we),
    .waddr_i (smem_waddr),
    .wdata_i (smem_wdata),
    .raddr_i (smem_raddr),
    .rdata_o (smem_rdata)
  );

  // timer memory: frequency, resolution and reference count of each timer
  pca_ram #(
    .WIDTH (pca_pkg::TMEM_W),
    .DEPTH (TIMERS)
  ) u_timer_mem (
    .clk_i   (clk_i),
    .we_i    (tmem_we),
    .waddr_i (tmem_waddr),
    .wdata_i (tmem_wdata),
    .raddr_i (tmem_raddr),
    .rdata_o (tmem_rdata)
  );

  // request sequencer
  pca_ctrl #(
    .GROUPS             (GROUPS),
    .CHANNELS_PER_GROUP (CHANNELS_PER_GROUP),
    .TIMERS_PER_GROUP   (TIMERS_PER_GROUP),
    .SLOTS              (SLOTS),
    .TIMERS             (TIMERS),
    .SW                 (SW),
    .TW                 (TW),
    .SMW                (SMW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o),
    .smem_we_o    (smem_we),
    .smem_waddr_o (smem_waddr),
    .smem_wdata_o (smem_wdata),
    .smem_raddr_o (smem_raddr),
    .smem_rdata_i (smem_rdata),
    .tmem_we_o    (tmem_we),
    .tmem_waddr_o (tmem_waddr),
    .tmem_wdata_o (tmem_wdata),
    .tmem_raddr_o (tmem_raddr),
    .tmem_rdata_i (tmem_rdata)
  );

endmodule

// ----- sim/pca_alloc_checker.sv -----
// response checker for the pwm channel and timer allocator
// tracks its own slot and timer tables, predicts each response, compares in order
// depends on pca_pkg only
module pca_alloc_checker
  import pca_pkg::*;
#(
  parameter int unsigned GROUPS             = 2,
  parameter int unsigned CHANNELS_PER_GROUP = 8,
  parameter int unsigned TIMERS_PER_GROUP   = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  pca_req_t in_req_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  pca_rsp_t out_rsp_i,
  output int       fail_count_o,
  output int       due_o
);

  localparam int unsigned SLOTS  = GROUPS * CHANNELS_PER_GROUP;
  localparam int unsigned TIMERS = GROUPS * TIMERS_PER_GROUP;

  // shadow of the allocation tables
  logic              slot_used [SLOTS];
  logic [PIN_W-1:0]  slot_owner[SLOTS];
  logic [TMR_W-1:0]  slot_tmr  [SLOTS];
  logic [FREQ_W-1:0] tmr_freq  [TIMERS];
  logic [RES_W-1:0]  tmr_res   [TIMERS];
  logic [RC_W-1:0]   tmr_refs  [TIMERS];

  // responses owed by the block, oldest first
  pca_rsp_t rsps_owed[$];

  // slot bound to a pin, or -1
  function automatic int slot_of_pin(logic [PIN_W-1:0] pin);
    for (int s = 0; s < SLOTS; s++)
      if (slot_used[s] && slot_owner[s] == pin)
        return s;
    return -1;
  endfunction

  // apply one request to the shadow tables and return the response it gives
  function automatic pca_rsp_t alloc_outcome(pca_req_t req);
    pca_rsp_t r;
    int       slot;
    int       tmr;
    int       first;
    logic     claim;
    r     = '0;
    slot  = -1;
    tmr   = -1;
    claim = 1'b0;
    case (req.action)
      ACT_OPEN: begin
        if (slot_of_pin(req.pin) >= 0) begin
          r.status = STS_PIN_OPEN;
          return r;
        end
        for (int s = 0; s < SLOTS; s++)
          if (slot < 0 && !slot_used[s])
            slot = s;
        if (slot < 0) begin
          r.status = STS_NO_RESOURCE;
          return r;
        end
        // only the slot's own group is searched
        first = (slot / CHANNELS_PER_GROUP) * TIMERS_PER_GROUP;
        for (int t = first; t < first + TIMERS_PER_GROUP; t++)
          if (tmr < 0 && tmr_freq[t] == req.frequency && tmr_res[t] == req.resolution)
            tmr = t;
        if (tmr < 0) begin
          for (int t = first; t < first + TIMERS_PER_GROUP; t++)
            if (tmr < 0 && tmr_refs[t] == '0)
              tmr = t;
          if (tmr < 0) begin
            r.status = STS_NO_RESOURCE;
            return r;
          end
          // resolution only matters when a timer gets reprogrammed
          if (req.resolution < RES_MIN || req.resolution > RES_MAX) begin
            r.status = STS_BAD_RES;
            return r;
          end
          tmr_freq[tmr] = req.frequency;
          tmr_res[tmr]  = req.resolution;
          claim         = 1'b1;
        end
        if (tmr_refs[tmr] < REF_MAX)
          tmr_refs[tmr] = tmr_refs[tmr] + 1'b1;
        slot_used[slot]   = 1'b1;
        slot_owner[slot]  = req.pin;
        slot_tmr[slot]    = TMR_W'(tmr);
        r.status          = STS_OK;
        r.channel_index   = CH_W'(slot);
        r.timer_id        = TMR_W'(tmr);
        r.configure_timer = claim;
      end
      ACT_CLOSE: begin
        slot = slot_of_pin(req.pin);
        if (slot < 0) begin
          r.status = STS_NOT_FOUND;
          return r;
        end
        tmr = slot_tmr[slot];
        // timer keeps its frequency and resolution after the last user leaves
        if (tmr_refs[tmr] != '0) begin
          tmr_refs[tmr]   = tmr_refs[tmr] - 1'b1;
          r.release_timer = (tmr_refs[tmr] == '0);
        end
        slot_used[slot] = 1'b0;
        r.status        = STS_OK;
        r.channel_index = CH_W'(slot);
        r.timer_id      = TMR_W'(tmr);
      end
      ACT_DUTY: begin
        slot = slot_of_pin(req.pin);
        if (slot < 0) begin
          r.status = STS_NOT_FOUND;
          return r;
        end
        r.status        = STS_OK;
        r.channel_index = CH_W'(slot);
        r.timer_id      = slot_tmr[slot];
        r.duty_out      = req.duty_value;
        r.fade_out      = req.fade_time;
        r.fading        = (req.fade_time != '0);
      end
      default: begin
        // unknown action: no change, all-zero response
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    pca_rsp_t want;
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_used[s]  = 1'b0;
        slot_owner[s] = '0;
        slot_tmr[s]   = '0;
      end
      for (int t = 0; t < TIMERS; t++) begin
        tmr_freq[t] = '0;
        tmr_res[t]  = '0;
        tmr_refs[t] = '0;
      end
      rsps_owed.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        rsps_owed.push_back(alloc_outcome(in_req_i));
      if (out_valid_i && !out_stall_i) begin
        if (rsps_owed.size() == 0) begin
          $error("response with no request outstanding");
          fail_count_o++;
        end else begin
          want = rsps_owed.pop_front();
          check_field("status", want.status, out_rsp_i.status);
          check_field("channel_index", want.channel_index, out_rsp_i.channel_index);
          check_field("timer_id", want.timer_id, out_rsp_i.timer_id);
          check_field("configure_timer", want.configure_timer, out_rsp_i.configure_timer);
          check_field("release_timer", want.release_timer, out_rsp_i.release_timer);
          check_field("duty_out", want.duty_out, out_rsp_i.duty_out);
          check_field("fade_out", want.fade_out, out_rsp_i.fade_out);
          check_field("fading", want.fading, out_rsp_i.fading);
        end
      end
    end
    due_o = rsps_owed.size();
  end

endmodule

// ----- sim/pwm_channel_timer_allocator_tb.sv -----
// testbench top for the pwm channel and timer allocator
// drives directed then random requests with random idling on both channels
// depends on pca_pkg, pwm_channel_timer_allocator and pca_alloc_checker
module pwm_channel_timer_allocator_tb;
  import pca_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 40;

  // action code with no meaning, the block must ignore it
  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  pca_req_t in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pca_rsp_t out_rsp;

  int fail_count;
  int due;
  int cycles      = 0;
  int hold_asked  = 0;
  int hold_given  = 0;
  int rx_left     = 0;
  bit quiet       = 1'b1;

  // frequency and resolution pairs that random opens share
  logic [FREQ_W-1:0] freq_pool[4];
  logic [RES_W-1:0]  res_pool [4];

  pwm_channel_timer_allocator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  pca_alloc_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .fail_count_o(fail_count),
    .due_o       (due)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pca_req_t make_req(logic [ACT_W-1:0] act, int pin, int freq, int res,
                                        int duty, int fade);
    pca_req_t q;
    q.action     = act;
    q.pin        = PIN_W'(pin);
    q.frequency  = FREQ_W'(freq);
    q.resolution = RES_W'(res);
    q.duty_value = DUTY_W'(duty);
    q.fade_time  = FADE_W'(fade);
    return q;
  endfunction

  // well-formed requests on a pin pool, with some noise mixed in
  function automatic pca_req_t random_req(int pool_base, int pool_size);
    pca_req_t q;
    int       r;
    int       k;
    q.action     = ACT_W'($urandom);
    q.pin        = PIN_W'($urandom);
    q.frequency  = FREQ_W'($urandom_range(0, 40000000));
    q.resolution = RES_W'($urandom);
    q.duty_value = DUTY_W'($urandom_range(0, 32768));
    q.fade_time  = FADE_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 95)
      q.pin = PIN_W'(pool_base + $urandom_range(0, pool_size - 1));
    if (r < 45) begin
      q.action = ACT_OPEN;
      if ($urandom_range(0, 9) < 8) begin
        k            = $urandom_range(0, 3);
        q.frequency  = freq_pool[k];
        q.resolution = res_pool[k];
      end
    end else if (r < 72) begin
      q.action = ACT_CLOSE;
    end else if (r < 95) begin
      q.action = ACT_DUTY;
      k = $urandom_range(0, 9);
      if (k < 3)
        q.fade_time = '0;
      else if (k == 3)
        q.fade_time = '1;
      if ($urandom_range(0, 19) == 0)
        q.duty_value = DUTY_W'(32768);
    end
    return q;
  endfunction

  // offer one request and hold it until accepted, then maybe idle
  task automatic send_request(input pca_req_t req);
    int gap;
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // response side stall: random runs, plus a long hold-off on demand
  always @(posedge clk) begin : receiver
    if (rx_left > 0) begin
      rx_left--;
    end else if (hold_given != hold_asked) begin
      hold_given++;
      out_stall <= 1'b1;
      rx_left = LONG_HOLD;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      rx_left = pick_gap();
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    int base;
    int size;
    freq_pool[0] = FREQ_W'(1000);
    res_pool[0]  = RES_W'(10);
    freq_pool[1] = FREQ_W'(5000);
    res_pool[1]  = RES_W'(12);
    freq_pool[2] = FREQ_W'(40000000);
    res_pool[2]  = RES_W'(15);
    freq_pool[3] = FREQ_W'(20000);
    res_pool[3]  = RES_W'(13);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    // zero frequency and resolution match an untouched timer
    send_request(make_req(ACT_OPEN, 0, 0, 0, 0, 0));
    send_request(make_req(ACT_OPEN, 63, 40000000, 15, 65535, 65535));
    // pin already open
    send_request(make_req(ACT_OPEN, 63, 40000000, 15, 0, 0));
    // resolution just outside the range when a timer is claimed
    send_request(make_req(ACT_OPEN, 5, 1000, 9, 0, 0));
    send_request(make_req(ACT_OPEN, 5, 1000, 16, 0, 0));
    send_request(make_req(ACT_OPEN, 5, 1000, 10, 0, 0));
    send_request(make_req(ACT_OPEN, 6, 2000, 12, 0, 0));
    // group has no match and no free timer
    send_request(make_req(ACT_OPEN, 7, 3000, 13, 0, 0));
    // shared timer, no reconfigure
    send_request(make_req(ACT_OPEN, 8, 1000, 10, 0, 0));
    send_request(make_req(ACT_DUTY, 63, 0, 0, 32768, 0));
    send_request(make_req(ACT_DUTY, 5, 0, 0, 0, 65535));
    send_request(make_req(ACT_DUTY, 9, 0, 0, 100, 7));
    send_request(make_req(ACT_CLOSE, 9, 0, 0, 0, 0));
    // last user of a timer leaves
    send_request(make_req(ACT_CLOSE, 63, 0, 0, 0, 0));
    // stale timer settings are reused without reconfigure
    send_request(make_req(ACT_OPEN, 62, 40000000, 15, 0, 0));
    send_request(make_req(ACT_CLOSE, 8, 0, 0, 0, 0));
    // unknown action with every field at its top
    send_request(make_req(ACT_UNKNOWN, 63, 67108863, 31, 65535, 65535));
    send_request(make_req(ACT_DUTY, 0, 0, 0, 12345, 1));
    // group one takes over once group zero's slots are used up
    for (int p = 20; p < 32; p++)
      send_request(make_req(ACT_OPEN, p, 1000, 10, 0, 0));
    // no free slot at all
    send_request(make_req(ACT_OPEN, 40, 1000, 10, 0, 0));

    // random phases on a growing pin pool
    for (int ph = 0; ph < 3; ph++) begin
      base         = $urandom_range(0, 63);
      size         = (ph == 0) ? 6 : ((ph == 1) ? 20 : 64);
      freq_pool[3] = FREQ_W'($urandom_range(0, 40000000));
      res_pool[3]  = RES_W'($urandom_range(8, 17));
      for (int n = 0; n < 345; n++) begin
        quiet = (n < 60);
        // receiver holds off while the sender keeps offering
        if (ph == 1 && n == 0)
          hold_asked++;
        send_request(random_req(base, size));
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && due == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/pca_pkg.sv
hw/rtl/pca_ram.sv
hw/rtl/pca_ctrl.sv
hw/rtl/pwm_channel_timer_allocator.sv
sim/pca_alloc_checker.sv
sim/pwm_channel_timer_allocator_tb.sv
